// File: design/adpcm_block_decoder_macros.svh
// Assertion helpers used by the decoder top-level source.
`ifndef ADPCM_BLOCK_DECODER_MACROS_SVH
`define ADPCM_BLOCK_DECODER_MACROS_SVH

// Condition must hold whenever the trigger holds.
`define ADBD_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define ADBD_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// File: design/adbd_pkg.sv
package adbd_pkg;

   localparam int BLOCK_BYTES = 16;
   localparam int POS_W = $clog2(BLOCK_BYTES);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [3:0] MAX_FILTER = 4'd4;
   localparam logic [POS_W-1:0] FIRST_DATA_POS = POS_W'(2);

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ERROR  = 2'd1,
      CMD_DECODE = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         clear_hist;
      logic [7:0]   data_byte;
      logic [2:0]   filter;
      logic [3:0]   shift;
   } cmd_type;

   function automatic logic signed [7:0] weight_recent(input logic [2:0] f);
      logic signed [7:0] w;
      unique case (f)
         3'd1:    w = 8'sd60;
         3'd2:    w = 8'sd115;
         3'd3:    w = 8'sd98;
         3'd4:    w = 8'sd122;
         default: w = 8'sd0;
      endcase
      return w;
   endfunction

   function automatic logic signed [7:0] weight_older(input logic [2:0] f);
      logic signed [7:0] w;
      unique case (f)
         3'd2:    w = -8'sd52;
         3'd3:    w = -8'sd55;
         3'd4:    w = -8'sd60;
         default: w = 8'sd0;
      endcase
      return w;
   endfunction

endpackage

// File: design/adpcm_block_decoder.sv
// Channel   Dir  tdata          tuser        tlast
// req_      in   data_byte[7:0] new_stream   -
// rsp_      out  sample[15:0]   bad_filter   last of the byte
//
// A byte is taken while the four-word command queue has room.
// Header and flag bytes are not decoded; a data byte is decoded in the back
// end one sample at a time, low nibble first, on the shared predictor multiply-add.
// Reset is synchronous and clears position, history, queue and output valid.
// A stall on rsp_ holds the back end; the queue then fills and stalls req_.
`include "adpcm_block_decoder_macros.svh"

module adpcm_block_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // new_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // sample
   output logic        rsp_tuser,   // bad_filter
   output logic        rsp_tlast
);
   import adbd_pkg::*;

   logic              q_full, q_empty, q_push, q_pop;
   cmd_type           push_cmd, head_cmd;
   logic [QCNT_W-1:0] q_count;

   adbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   adbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full),
      .count    (q_count)
   );

   adbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `ADBD_ASSERT_NOW(a_bad_word_form, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata == 16'd0 && rsp_tlast, "bad filter word must be zero and last")
   `ADBD_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1,
      q_count <= QCNT_W'(QUEUE_DEPTH), "command queue count beyond depth")
   `ADBD_ASSERT_NOW(a_first_sample_held, clock, reset,
      rsp_tvalid && !rsp_tuser && !rsp_tlast, !q_empty,
      "data command left the queue before its second sample")
   `ADBD_ASSERT_NEXT(a_full_blocks_req, clock, reset, q_full && !q_pop,
      !req_tready, "input taken while the queue stays full")

endmodule

// File: design/adbd_front.sv
module adbd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // data_byte
   input  logic             req_tuser,   // new_stream
   input  logic             q_full,
   output logic             q_push,
   output adbd_pkg::cmd_type q_cmd
);
   import adbd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in, pos_cur;
   logic [2:0]       filter_ff, filter_in;
   logic [3:0]       shift_ff, shift_in;
   logic             invalid_ff, invalid_in, invalid_cur;
   logic             accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   always_comb begin
      pos_cur     = req_tuser ? '0 : pos_ff;
      invalid_cur = req_tuser ? 1'b0 : invalid_ff;
      pos_in      = pos_ff;
      filter_in   = filter_ff;
      shift_in    = shift_ff;
      invalid_in  = invalid_ff;
      q_push      = 1'b0;
      q_cmd.kind       = CMD_CLEAR;
      q_cmd.clear_hist = req_tuser;
      q_cmd.data_byte  = req_tdata;
      q_cmd.filter     = filter_ff;
      q_cmd.shift      = shift_ff;
      if (accept) begin
         pos_in     = (pos_cur == POS_W'(BLOCK_BYTES - 1)) ? '0 : pos_cur + 1'b1;
         invalid_in = invalid_cur;
         if (pos_cur == '0) begin
            if (req_tdata[7:4] > MAX_FILTER) begin
               invalid_in = 1'b1;
               q_push     = 1'b1;
               q_cmd.kind = CMD_ERROR;
            end else begin
               invalid_in = 1'b0;
               filter_in  = req_tdata[6:4];
               shift_in   = req_tdata[3:0];
               q_push     = req_tuser;
               q_cmd.kind = CMD_CLEAR;
            end
         end else if (pos_cur >= FIRST_DATA_POS && !invalid_cur) begin
            q_push     = 1'b1;
            q_cmd.kind = CMD_DECODE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         filter_ff  <= '0;
         shift_ff   <= '0;
         invalid_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         filter_ff  <= filter_in;
         shift_ff   <= shift_in;
         invalid_ff <= invalid_in;
      end
   end

endmodule

// File: design/adbd_queue.sv
module adbd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  adbd_pkg::cmd_type        push_cmd,
   input  logic                     pop,
   output adbd_pkg::cmd_type        head_cmd,
   output logic                     empty,
   output logic                     full,
   output logic [adbd_pkg::QCNT_W-1:0] count
);
   import adbd_pkg::*;

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign count    = cnt_ff;
   assign head_cmd = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: design/adbd_back.sv
module adbd_back (
   input  logic              clock,
   input  logic              reset,
   input  adbd_pkg::cmd_type head_cmd,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // sample
   output logic              rsp_tuser,   // bad_filter
   output logic              rsp_tlast
);
   import adbd_pkg::*;

   typedef enum logic [1:0] {
      BK_LOW  = 2'b01,
      BK_HIGH = 2'b10
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic signed [15:0] recent_ff, recent_in, older_ff, older_in;
   logic signed [15:0] recent_use, older_use;
   logic               valid_ff, valid_in;
   logic [15:0]        data_ff, data_in;
   logic               bad_ff, bad_in, last_ff, last_in;
   logic               slot_free, go, clr;
   logic [3:0]         nib;
   logic signed [15:0] scaled;
   logic signed [23:0] prod_recent, prod_older;
   logic signed [24:0] pred;
   logic signed [19:0] total;
   logic signed [15:0] sample;

   assign slot_free  = !valid_ff || rsp_tready;
   assign go         = !q_empty && slot_free;
   assign clr        = head_cmd.clear_hist && (state_ff == BK_LOW);
   assign recent_use = clr ? 16'sd0 : recent_ff;
   assign older_use  = clr ? 16'sd0 : older_ff;
   assign nib        = (state_ff == BK_LOW) ? head_cmd.data_byte[3:0]
                                            : head_cmd.data_byte[7:4];

   always_comb begin
      scaled      = $signed({nib, 12'd0}) >>> head_cmd.shift;
      prod_recent = recent_use * weight_recent(head_cmd.filter);
      prod_older  = older_use * weight_older(head_cmd.filter);
      pred        = {prod_recent[23], prod_recent} + {prod_older[23], prod_older}
                    + 25'sd32;
      total       = {pred[24], pred[24:6]} + {{4{scaled[15]}}, scaled};
      if (total > 20'sd32767) begin
         sample = 16'sd32767;
      end else if (total < -20'sd32768) begin
         sample = -16'sd32768;
      end else begin
         sample = total[15:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      recent_in = recent_ff;
      older_in  = older_ff;
      valid_in  = valid_ff && !rsp_tready;
      data_in   = data_ff;
      bad_in    = bad_ff;
      last_in   = last_ff;
      q_pop     = 1'b0;
      if (!q_empty) begin
         unique case (head_cmd.kind)
            CMD_CLEAR: begin
               q_pop     = 1'b1;
               recent_in = 16'sd0;
               older_in  = 16'sd0;
            end
            CMD_ERROR: begin
               if (go) begin
                  q_pop    = 1'b1;
                  valid_in = 1'b1;
                  data_in  = 16'd0;
                  bad_in   = 1'b1;
                  last_in  = 1'b1;
                  if (head_cmd.clear_hist) begin
                     recent_in = 16'sd0;
                     older_in  = 16'sd0;
                  end
               end
            end
            CMD_DECODE: begin
               if (go) begin
                  valid_in  = 1'b1;
                  data_in   = sample;
                  bad_in    = 1'b0;
                  last_in   = (state_ff == BK_HIGH);
                  recent_in = sample;
                  older_in  = recent_use;
                  q_pop     = (state_ff == BK_HIGH);
                  state_in  = (state_ff == BK_HIGH) ? BK_LOW : BK_HIGH;
               end
            end
            default: begin
               q_pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      bad_ff  <= bad_in;
      last_ff <= last_in;
      if (reset) begin
         state_ff  <= BK_LOW;
         recent_ff <= 16'sd0;
         older_ff  <= 16'sd0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         recent_ff <= recent_in;
         older_ff  <= older_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = bad_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: verif/testbench.sv
module testbench;
   import adbd_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES = 300;
   localparam int ITEM_TARGET = 500;
   localparam int TAIL_START = 440;

   typedef struct packed {
      logic [15:0] sample;
      logic        bad_filter;
      logic        last;
   } sample_word_type;

   class adpcm_scoreboard;
      logic [3:0]         position;
      logic [2:0]         filter;
      logic [3:0]         shift;
      bit                 invalid;
      logic signed [15:0] recent;
      logic signed [15:0] older;
      sample_word_type    pending[$];
      int                 failures;

      function new();
         position = '0;
         filter   = '0;
         shift    = '0;
         invalid  = 1'b0;
         recent   = '0;
         older    = '0;
         failures = 0;
      endfunction

      function logic signed [15:0] decode_nibble(logic [3:0] nib);
         int raw;
         int scaled;
         int pred;
         int sum;
         int wr;
         int wo;
         case (filter)
            3'd1:    begin wr = 60;  wo = 0;   end
            3'd2:    begin wr = 115; wo = -52; end
            3'd3:    begin wr = 98;  wo = -55; end
            3'd4:    begin wr = 122; wo = -60; end
            default: begin wr = 0;   wo = 0;   end
         endcase
         raw = int'($signed(nib));
         scaled = (raw * 4096) >>> shift;
         pred = int'(recent) * wr + int'(older) * wo + 32;
         sum = scaled + (pred >>> 6);
         if (sum > 32767) sum = 32767;
         if (sum < -32768) sum = -32768;
         older = recent;
         recent = 16'(sum);
         return recent;
      endfunction

      function void note_byte(logic [7:0] data_byte, logic new_stream);
         sample_word_type w;
         if (new_stream) begin
            position = '0;
            invalid  = 1'b0;
            recent   = '0;
            older    = '0;
         end
         if (position == 4'd0) begin
            if (data_byte[7:4] > MAX_FILTER) begin
               invalid = 1'b1;
               w.sample = '0;
               w.bad_filter = 1'b1;
               w.last = 1'b1;
               pending.push_back(w);
            end else begin
               invalid = 1'b0;
               filter = data_byte[6:4];
               shift = data_byte[3:0];
            end
         end else if (position >= FIRST_DATA_POS && !invalid) begin
            w.sample = decode_nibble(data_byte[3:0]);
            w.bad_filter = 1'b0;
            w.last = 1'b0;
            pending.push_back(w);
            w.sample = decode_nibble(data_byte[7:4]);
            w.last = 1'b1;
            pending.push_back(w);
         end
         position = position + 4'd1;
      endfunction

      function void check_word(logic [15:0] sample, logic bad_filter, logic last);
         sample_word_type w;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected word: sample %0d bad_filter %0b last %0b",
                        $signed(sample), bad_filter, last);
            return;
         end
         w = pending.pop_front();
         if (w.sample !== sample || w.bad_filter !== bad_filter || w.last !== last) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected sample %0d bad_filter %0b last %0b, got %0d %0b %0b",
                        $signed(w.sample), w.bad_filter, w.last,
                        $signed(sample), bad_filter, last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // data_byte
   logic        req_tuser;    // new_stream
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // sample
   logic        rsp_tuser;    // bad_filter
   logic        rsp_tlast;

   adpcm_scoreboard sb = new();
   int  items_sent;
   int  words_out;
   int  idle_cycles;
   bit  tail_phase;
   bit  held_off;
   bit  aligned;

   adpcm_block_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
            words_out++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // The single long hold-off lets the command queue fill so the input stalls.
   initial begin
      rsp_tready = 1'b0;
      held_off = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held_off && words_out >= 80) begin
            held_off = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready = 1'b1;
         end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] data_byte, input logic new_stream);
      int gap;
      @(negedge clock);
      if (!tail_phase && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = data_byte;
      req_tuser = new_stream;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (items_sent >= TAIL_START) tail_phase = 1'b1;
   endtask

   task automatic send_block();
      logic [7:0] header;
      logic       new_stream;
      int         cut;
      header[7:4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(5, 15))
                                                : 4'($urandom_range(0, 4));
      header[3:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(12, 15))
                                                : 4'($urandom_range(0, 12));
      new_stream = !aligned || ($urandom_range(0, 5) == 0);
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : BLOCK_BYTES;
      send_byte(header, new_stream);
      for (int i = 1; i < cut; i++)
         send_byte(8'($urandom), 1'b0);
      aligned = (cut == BLOCK_BYTES);
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      aligned = 1'b0;
   endtask

   initial begin
      logic [8:0] directed[$];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      items_sent = 0;
      tail_phase = 1'b0;
      aligned = 1'b1;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Each entry is {new_stream, data_byte}. The first run saturates the
      // strongest filter; later ones cover large shifts, a bad filter and a
      // restart in the middle of a block.
      directed = '{9'h140, 9'h0ff, 9'h077, 9'h077, 9'h077, 9'h077, 9'h088,
                   9'h12d, 9'h000, 9'h088, 9'h07f,
                   9'h15f, 9'h012, 9'h0ff,
                   9'h10f, 9'h0ff, 9'h080,
                   9'h13c, 9'h000, 9'h008, 9'h080,
                   9'h11c, 9'h000, 9'h0f7};
      foreach (directed[i])
         send_byte(directed[i][7:0], directed[i][8]);
      aligned = 1'b0;

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_block();
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/adbd_pkg.sv
design/adbd_front.sv
design/adbd_queue.sv
design/adbd_back.sv
design/adpcm_block_decoder.sv
verif/testbench.sv
